[rtl/pfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, codes and sizes of the paged frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int OFFSET_BITS      = 10;
  localparam int PAGE_NUMBER_BITS = 10;
  localparam int MAX_PROCESSES    = 7;

  localparam int ACT_W  = 2;
  localparam int PID_W  = 3;
  localparam int SIZE_W = 21;
  localparam int VA_W   = 20;
  localparam int BYTE_W = 8;
  localparam int STS_W  = 2;

  localparam int FRAMES    = 1 << PAGE_NUMBER_BITS;
  localparam int PA_W      = OFFSET_BITS + PAGE_NUMBER_BITS;
  localparam int MAP_AW    = PID_W + PAGE_NUMBER_BITS;
  localparam int MAP_DW    = PAGE_NUMBER_BITS + 1;
  localparam int PID_SLOTS = 1 << PID_W;
  localparam int PAGES_W   = SIZE_W + 1 - OFFSET_BITS;
  localparam int CMP_W     = 40;

  localparam logic [CMP_W-1:0] MEM_BYTES = CMP_W'(1) << PA_W;

  localparam logic [STS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STS_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STS_W-1:0] ST_FAULT   = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_ALLOC,
    S_LOOKUP,
    S_ACCESS,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic accept_en;
    logic decide;
    logic alloc_step;
    logic map_rd;
    logic ram_acc;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic    clear_done;
    logic    in_valid;
    action_t in_action;
    logic    alloc_ok;
    logic    alloc_last;
    logic    out_free;
  } stat_t;

endpackage

[rtl/pfa_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_in_if
// Request channel: one word is one allocate, read or write request.
// ----------------------------------------------------------------------------
interface pfa_in_if
  import pfa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [PID_W-1:0]  process_id;
  logic [SIZE_W-1:0] alloc_size;
  logic [VA_W-1:0]   virtual_address;
  logic [BYTE_W-1:0] write_byte;

  modport source (output valid, action, process_id, alloc_size, virtual_address,
                  write_byte, input ready);
  modport sink (input valid, action, process_id, alloc_size, virtual_address,
                write_byte, output ready);
endinterface

[rtl/pfa_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_out_if
// Result channel: one word is the answer to one request.
// ----------------------------------------------------------------------------
interface pfa_out_if
  import pfa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic [VA_W-1:0]   alloc_address;
  logic [BYTE_W-1:0] read_byte;

  modport source (output valid, status, alloc_address, read_byte, input ready);
  modport sink (input valid, status, alloc_address, read_byte, output ready);
endinterface

[rtl/pfa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer that steps the datapath through clearing, allocation and access.
// ----------------------------------------------------------------------------
module pfa_ctrl
  import pfa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (st.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept_en = 1'b1;
        if (st.in_valid) begin
          case (st.in_action)
            ACT_ALLOC: state_nxt = S_DECIDE;
            ACT_READ:  state_nxt = S_LOOKUP;
            ACT_WRITE: state_nxt = S_LOOKUP;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = st.alloc_ok ? S_ALLOC : S_RESP;
      end
      S_ALLOC: begin
        cmd.alloc_step = 1'b1;
        if (st.alloc_last) state_nxt = S_RESP;
      end
      S_LOOKUP: begin
        cmd.map_rd = 1'b1;
        state_nxt  = S_ACCESS;
      end
      S_ACCESS: begin
        cmd.ram_acc = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

[rtl/pfa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_dp
// Datapath: request registers, break pointers, page map, physical RAM and
// the result register.
// ----------------------------------------------------------------------------
module pfa_dp
  import pfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       st,
  pfa_in_if.sink      in_word,
  pfa_out_if.source   out_word
);

  logic [PA_W-1:0]             clr_r;
  logic [PAGE_NUMBER_BITS:0]   next_frame_r;
  logic [SIZE_W-1:0]           bp_r [PID_SLOTS];
  logic                        out_valid_r;

  action_t                     act_r;
  logic [PID_W-1:0]            pid_r;
  logic [VA_W-1:0]             va_r;
  logic [BYTE_W-1:0]           wb_r;
  logic [PAGES_W-1:0]          pages_r;
  logic                        size_zero_r;
  logic [PAGES_W-1:0]          rem_r;
  logic [PAGE_NUMBER_BITS-1:0] vpage_r;
  logic [STS_W-1:0]            sts_r;
  logic [VA_W-1:0]             addr_r;
  logic                        rd_ok_r;
  logic [MAP_DW-1:0]           map_q_r;
  logic [BYTE_W-1:0]           ram_q_r;
  logic [STS_W-1:0]            out_sts_r;
  logic [VA_W-1:0]             out_addr_r;
  logic [BYTE_W-1:0]           out_rb_r;

  logic [MAP_DW-1:0]           map_mem [1 << MAP_AW];
  logic [BYTE_W-1:0]           ram_mem [1 << PA_W];

  logic                        load;
  logic [SIZE_W:0]             size_sum;
  logic [CMP_W-1:0]            need_end;
  logic [CMP_W-1:0]            free_cnt;
  logic                        pid_ok;
  logic                        alloc_ok;
  logic                        vpage_oor;
  logic                        fault;
  logic [PA_W-1:0]             pa;
  logic [SIZE_W-1:0]           bp_cur;

  assign load     = in_word.valid && cmd.accept_en;
  assign size_sum = {1'b0, in_word.alloc_size} + (SIZE_W + 1)'((1 << OFFSET_BITS) - 1);
  assign bp_cur   = bp_r[pid_r];
  assign need_end = CMP_W'(bp_cur) + (CMP_W'(pages_r) << OFFSET_BITS);
  assign free_cnt = CMP_W'(FRAMES) - CMP_W'(next_frame_r);
  assign pid_ok   = (pid_r != '0) && (CMP_W'(pid_r) <= CMP_W'(MAX_PROCESSES));
  assign alloc_ok = pid_ok && !size_zero_r && (need_end <= MEM_BYTES) &&
                    (CMP_W'(pages_r) <= free_cnt);
  assign vpage_oor = (CMP_W'(va_r) >> OFFSET_BITS) >= CMP_W'(FRAMES);
  assign fault    = !pid_ok || vpage_oor || !map_q_r[PAGE_NUMBER_BITS];
  assign pa       = {map_q_r[PAGE_NUMBER_BITS-1:0], va_r[OFFSET_BITS-1:0]};

  assign in_word.ready = cmd.accept_en;

  assign st.clear_done = &clr_r;
  assign st.in_valid   = in_word.valid;
  assign st.in_action  = action_t'(in_word.action);
  assign st.alloc_ok   = alloc_ok;
  assign st.alloc_last = (rem_r == '0);
  assign st.out_free   = !out_valid_r || out_word.ready;

  assign out_word.valid         = out_valid_r;
  assign out_word.status        = out_sts_r;
  assign out_word.alloc_address = out_addr_r;
  assign out_word.read_byte     = out_rb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= '0;
      next_frame_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < PID_SLOTS; i++) bp_r[i] <= '0;
    end else begin
      if (cmd.clr_en && !(&clr_r)) clr_r <= clr_r + 1'b1;
      if (cmd.decide && alloc_ok) bp_r[pid_r] <= need_end[SIZE_W-1:0];
      if (cmd.alloc_step) next_frame_r <= next_frame_r + 1'b1;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      act_r       <= action_t'(in_word.action);
      pid_r       <= in_word.process_id;
      va_r        <= in_word.virtual_address;
      wb_r        <= in_word.write_byte;
      pages_r     <= size_sum[SIZE_W:OFFSET_BITS];
      size_zero_r <= (in_word.alloc_size == '0);
      sts_r       <= ST_FAULT;
      addr_r      <= '0;
      rd_ok_r     <= 1'b0;
    end
    if (cmd.decide) begin
      rem_r   <= pages_r - 1'b1;
      vpage_r <= bp_cur[OFFSET_BITS +: PAGE_NUMBER_BITS];
      if (alloc_ok) begin
        sts_r  <= ST_OK;
        addr_r <= bp_cur[VA_W-1:0];
      end else begin
        sts_r  <= ST_REFUSED;
      end
    end
    if (cmd.alloc_step) begin
      rem_r   <= rem_r - 1'b1;
      vpage_r <= vpage_r + 1'b1;
    end
    if (cmd.ram_acc) begin
      sts_r   <= fault ? ST_FAULT : ST_OK;
      rd_ok_r <= !fault && (act_r == ACT_READ);
    end
    if (cmd.res_load) begin
      out_sts_r  <= sts_r;
      out_addr_r <= addr_r;
      out_rb_r   <= rd_ok_r ? ram_q_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en && (clr_r[PA_W-1:MAP_AW] == '0)) begin
      map_mem[clr_r[MAP_AW-1:0]] <= '0;
    end else if (cmd.alloc_step) begin
      map_mem[{pid_r, vpage_r}] <= {1'b1, next_frame_r[PAGE_NUMBER_BITS-1:0]};
    end
    if (cmd.map_rd) map_q_r <= map_mem[{pid_r, va_r[OFFSET_BITS +: PAGE_NUMBER_BITS]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      ram_mem[clr_r] <= '0;
    end else if (cmd.ram_acc && !fault && (act_r == ACT_WRITE)) begin
      ram_mem[pa] <= wb_r;
    end
    if (cmd.ram_acc) ram_q_r <= ram_mem[pa];
  end

endmodule

[rtl/paged_frame_allocator_mmu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_frame_allocator_mmu
// Page allocator and per-process address translation with byte RAM.
// ----------------------------------------------------------------------------
// Read and write go through a map lookup and then a RAM access before the result.
// Allocate is decided first; if granted, one page map entry is written a cycle, one per page.
// One request is in work at a time; a finished word waits in the output register.
// After reset a clearing pass zeroes the RAM and the page map,
// one address a cycle; no request is accepted until it ends.
module paged_frame_allocator_mmu
  import pfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  pfa_in_if.sink    in_word,
  pfa_out_if.source out_word
);

  cmd_t  cmd;
  stat_t st;

  pfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  pfa_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .in_word  (in_word),
    .out_word (out_word)
  );

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> (out_word.status == ST_OK || out_word.status == ST_REFUSED ||
                        out_word.status == ST_FAULT))
    else $error("result status code out of range");

  a_refused_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.status != ST_OK) |-> (out_word.alloc_address == '0))
    else $error("failed request returned a nonzero address");

  a_fail_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.status != ST_OK) |-> (out_word.read_byte == '0))
    else $error("failed request returned a nonzero byte");

endmodule
